// File: rtl/core/bremon_pkg.sv
// Shared constants, types and codes for the busy ratio monitor.
// No dependencies; every other file of the block imports this package.
package bremon_pkg;

	localparam int HISTORY_DEPTH_DEF = 256;
	localparam int WORD_W            = 64;
	localparam int AVG_W             = 17;
	localparam int DECAY_W           = 16;
	localparam int BAR_W             = 10;
	localparam int AGE_W             = 8;
	localparam int Q_FRAC            = 16;
	localparam int CFG_DATA_W        = 16;
	localparam int CFG_INDEX_W       = 1;

	localparam logic [AVG_W-1:0]   Q_ONE       = 17'h10000;
	localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd64884;
	localparam logic [BAR_W-1:0]   BAR_RESET   = 10'd64;
	localparam logic [BAR_W-1:0]   BAR_MAX     = 10'd1023;
	localparam logic [WORD_W-1:0]  ROUND_HALF  = 64'd32768;

	localparam logic [CFG_INDEX_W-1:0] CFG_DECAY = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] CFG_BAR   = 1'b1;

	localparam logic OPC_SAMPLE = 1'b0;
	localparam logic OPC_READ   = 1'b1;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_MUL = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic [WORD_W-1:0] value;
		logic              borrow;
	} alu_res_t;

endpackage

// File: rtl/core/bremon_ifs.sv
// Channel interfaces of the busy ratio monitor: command items in, result items out.
// Depends on bremon_pkg for the field widths.
interface bremon_cmd_if import bremon_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [WORD_W-1:0] user_ticks;
	logic [WORD_W-1:0] nice_ticks;
	logic [WORD_W-1:0] system_ticks;
	logic [WORD_W-1:0] idle_ticks;
	logic [WORD_W-1:0] iowait_ticks;
	logic [AGE_W-1:0]  age_index;

	modport source (output valid, opcode, user_ticks, nice_ticks, system_ticks,
		idle_ticks, iowait_ticks, age_index, input ready);
	modport sink (input valid, opcode, user_ticks, nice_ticks, system_ticks,
		idle_ticks, iowait_ticks, age_index, output ready);
endinterface

interface bremon_rsp_if import bremon_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [AVG_W-1:0] average_value;
	logic [BAR_W-1:0] bar_height;
	logic             empty_interval;

	modport source (output valid, average_value, bar_height, empty_interval,
		input ready);
	modport sink (input valid, average_value, bar_height, empty_interval,
		output ready);
endinterface

// File: rtl/core/bremon_alu.sv
// Shared arithmetic unit: 64-bit add, 64-bit subtract with borrow, 17x17 multiply.
// Depends on bremon_pkg; the sequencer registers values but branches on borrow.
module bremon_alu import bremon_pkg::*; (
	input  alu_op_t           op,
	input  logic [WORD_W-1:0] a,
	input  logic [WORD_W-1:0] b,
	output alu_res_t          res
);

	logic [WORD_W:0]        wide;
	logic [2*AVG_W-1:0]     prod;

	always_comb begin
		wide = '0;
		prod = a[AVG_W-1:0] * b[AVG_W-1:0];
		unique case (op)
			ALU_ADD: wide = {1'b0, a} + {1'b0, b};
			ALU_SUB: wide = {1'b0, a} - {1'b0, b};
			ALU_MUL: wide = {{(WORD_W+1-2*AVG_W){1'b0}}, prod};
			default: wide = '0;
		endcase
		res.value  = wide[WORD_W-1:0];
		res.borrow = wide[WORD_W];
	end

endmodule

// File: rtl/core/bremon_ring.sv
// History ring storage: one write port and one read port with registered data.
// Depends on bremon_pkg for the entry width.
module bremon_ring import bremon_pkg::*; #(
	parameter int DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [AVG_W-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [AVG_W-1:0]         rdata
);

	logic [AVG_W-1:0] mem [DEPTH];
	logic [AVG_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/busy_ratio_ema_monitor_top.sv
// Busy ratio monitor top level: sequencer, state and configuration registers.
// Depends on bremon_pkg, bremon_ifs, bremon_alu and bremon_ring.
// Usage: cmd carries one item at a time (valid/ready). An item with opcode 0
// holds five cumulative tick counters; the block forms busy and total deltas
// against the previous sample, divides them to a Q1.16 utilization, folds it
// into a moving average weighted by decay_factor, stores the average in the
// history ring and returns it with its bar height. An item with opcode 1
// returns the ring entry at age_index (0 is the oldest) scaled to a bar.
// rsp gives exactly one result item per command item.
// Timing: everything runs through one shared adder/subtractor/multiplier.
// A sample runs the sums, the deltas, a compare and a bit-serial division
// (skipped when the total delta is zero or the busy delta is not below it),
// then the weighting, rounding and bar steps; a read wraps the ring index by
// repeated subtraction of HISTORY_DEPTH. cmd.ready is high only while the
// sequencer is idle, so a new item is taken only after the last one is done.
// A finished result waits in the output register; the next item may be taken
// meanwhile and completes once rsp.ready has emptied that register.
// Reset clears the average, previous sums, ring position and output valid flag
// and loads the configuration defaults; the ring reads as zero until written,
// tracked by the write position and a wrap flag, so no clearing pass is needed.
module busy_ratio_ema_monitor_top import bremon_pkg::*; #(
	parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	bremon_cmd_if.sink             cmd,
	bremon_rsp_if.source           rsp
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int IW = $clog2(HISTORY_DEPTH + 255);

	typedef enum logic [17:0] {
		S_IDLE = 18'h00001,
		S_ADD1 = 18'h00002,
		S_ADD2 = 18'h00004,
		S_ADD3 = 18'h00008,
		S_ADD4 = 18'h00010,
		S_DB   = 18'h00020,
		S_DT   = 18'h00040,
		S_CMP  = 18'h00080,
		S_DIV  = 18'h00100,
		S_MUL1 = 18'h00200,
		S_MUL2 = 18'h00400,
		S_SUM  = 18'h00800,
		S_RND  = 18'h01000,
		S_BAR  = 18'h02000,
		S_DONE = 18'h04000,
		S_RED  = 18'h08000,
		S_RD   = 18'h10000,
		S_SPARE = 18'h20000
	} state_t;

	state_t              state_q;
	logic                opc_q;
	logic [WORD_W-1:0]   user_q, nice_q, system_q, idle_q, iowait_q;
	logic [WORD_W-1:0]   acc_q, busy_q, total_q, rem_q, den_q, prod_q;
	logic [AVG_W-1:0]    quo_q, val_q;
	logic [BAR_W-1:0]    barv_q;
	logic                empty_q;
	logic [3:0]          cnt_q;
	logic [IW-1:0]       idx_q;

	logic [WORD_W-1:0]   prev_busy_q, prev_total_q;
	logic [AVG_W-1:0]    avg_q;
	logic [AW-1:0]       wp_q;
	logic                wrapped_q;
	logic [DECAY_W-1:0]  decay_q;
	logic [BAR_W-1:0]    bar_q;

	logic                out_valid_q;
	logic [AVG_W-1:0]    out_avg_q;
	logic [BAR_W-1:0]    out_bar_q;
	logic                out_empty_q;

	alu_op_t             alu_op;
	logic [WORD_W-1:0]   alu_a, alu_b;
	alu_res_t            alu_res;
	logic [WORD_W-1:0]   rem_shl;
	logic                load_out;
	logic                ring_we;
	logic [AVG_W-1:0]    ring_rdata;
	logic                entry_ok;

	bremon_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	bremon_ring #(.DEPTH(HISTORY_DEPTH)) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (wp_q),
		.wdata (val_q),
		.raddr (idx_q[AW-1:0]),
		.rdata (ring_rdata)
	);

	assign cmd.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.average_value  = out_avg_q;
	assign rsp.bar_height     = out_bar_q;
	assign rsp.empty_interval = out_empty_q;

	assign rem_shl  = {rem_q[WORD_W-2:0], 1'b0};
	assign load_out = !out_valid_q || rsp.ready;
	assign ring_we  = (state_q == S_DONE) && load_out && (opc_q == OPC_SAMPLE);
	assign entry_ok = wrapped_q || (idx_q[AW-1:0] < wp_q);

	// Operand selection for the shared unit, one operation per sequencer step.
	always_comb begin
		alu_op = ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		unique case (state_q)
			S_ADD1: begin alu_a = user_q;  alu_b = nice_q;   end
			S_ADD2: begin alu_a = acc_q;   alu_b = system_q; end
			S_ADD3: begin alu_a = busy_q;  alu_b = idle_q;   end
			S_ADD4: begin alu_a = acc_q;   alu_b = iowait_q; end
			S_DB: begin
				alu_op = ALU_SUB;
				alu_a  = busy_q;
				alu_b  = prev_busy_q;
			end
			S_DT: begin
				alu_op = ALU_SUB;
				alu_a  = total_q;
				alu_b  = prev_total_q;
			end
			S_CMP: begin
				alu_op = ALU_SUB;
				alu_a  = rem_q;
				alu_b  = den_q;
			end
			S_DIV: begin
				alu_op = ALU_SUB;
				alu_a  = rem_shl;
				alu_b  = den_q;
			end
			S_MUL1: begin
				alu_op = ALU_MUL;
				alu_a  = WORD_W'(avg_q);
				alu_b  = WORD_W'(decay_q);
			end
			S_MUL2: begin
				alu_op = ALU_MUL;
				alu_a  = WORD_W'(quo_q);
				alu_b  = WORD_W'(Q_ONE - {1'b0, decay_q});
			end
			S_SUM: begin alu_a = prod_q; alu_b = acc_q;      end
			S_RND: begin alu_a = prod_q; alu_b = ROUND_HALF; end
			S_BAR: begin
				alu_op = ALU_MUL;
				alu_a  = WORD_W'(val_q);
				alu_b  = WORD_W'(bar_q);
			end
			S_RED: begin
				alu_op = ALU_SUB;
				alu_a  = WORD_W'(idx_q);
				alu_b  = WORD_W'(HISTORY_DEPTH);
			end
			default: begin
				alu_op = ALU_ADD;
			end
		endcase
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			prev_busy_q  <= '0;
			prev_total_q <= '0;
			avg_q        <= '0;
			wp_q         <= '0;
			wrapped_q    <= 1'b0;
			decay_q      <= DECAY_RESET;
			bar_q        <= BAR_RESET;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DECAY: decay_q <= cfg_data[DECAY_W-1:0];
					CFG_BAR:   bar_q   <= cfg_data[BAR_W-1:0];
					default:   decay_q <= decay_q;
				endcase
			end
			// A finished item reloads the output register in the same cycle instead.
			if (out_valid_q && rsp.ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						state_q <= (cmd.opcode == OPC_READ) ? S_RED : S_ADD1;
					end
				end
				S_ADD1: state_q <= S_ADD2;
				S_ADD2: state_q <= S_ADD3;
				S_ADD3: state_q <= S_ADD4;
				S_ADD4: state_q <= S_DB;
				S_DB:   state_q <= S_DT;
				S_DT:   state_q <= S_CMP;
				S_CMP: begin
					cnt_q <= '0;
					if (den_q == '0 || !alu_res.borrow) begin
						state_q <= S_MUL1;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'(Q_FRAC - 1)) begin
						state_q <= S_MUL1;
					end
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_SUM;
				S_SUM:  state_q <= S_RND;
				S_RND:  state_q <= S_BAR;
				S_BAR:  state_q <= S_DONE;
				S_RED: begin
					if (alu_res.borrow) begin
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_BAR;
				S_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (opc_q == OPC_SAMPLE) begin
							prev_busy_q  <= busy_q;
							prev_total_q <= total_q;
							avg_q        <= val_q;
							if (wp_q == AW'(HISTORY_DEPTH - 1)) begin
								wp_q      <= '0;
								wrapped_q <= 1'b1;
							end else begin
								wp_q <= wp_q + 1'b1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Item payload and intermediate results.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					opc_q    <= cmd.opcode;
					user_q   <= cmd.user_ticks;
					nice_q   <= cmd.nice_ticks;
					system_q <= cmd.system_ticks;
					idle_q   <= cmd.idle_ticks;
					iowait_q <= cmd.iowait_ticks;
					idx_q    <= IW'(wp_q) + IW'(cmd.age_index);
					empty_q  <= 1'b0;
				end
			end
			S_ADD1: acc_q   <= alu_res.value;
			S_ADD2: busy_q  <= alu_res.value;
			S_ADD3: acc_q   <= alu_res.value;
			S_ADD4: total_q <= alu_res.value;
			S_DB:   rem_q   <= alu_res.value;
			S_DT:   den_q   <= alu_res.value;
			S_CMP: begin
				if (den_q == '0) begin
					empty_q <= 1'b1;
					quo_q   <= '0;
				end else if (!alu_res.borrow) begin
					quo_q <= Q_ONE;
				end else begin
					quo_q <= '0;
				end
			end
			S_DIV: begin
				// The bit shifted out of the remainder counts as a carry into the compare.
				if (rem_q[WORD_W-1] || !alu_res.borrow) begin
					rem_q <= alu_res.value;
					quo_q <= {quo_q[AVG_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_shl;
					quo_q <= {quo_q[AVG_W-2:0], 1'b0};
				end
			end
			S_MUL1: prod_q <= alu_res.value;
			S_MUL2: acc_q  <= alu_res.value;
			S_SUM:  prod_q <= alu_res.value;
			S_RND: begin
				if (alu_res.value[WORD_W-1:Q_FRAC] > (WORD_W - Q_FRAC)'(Q_ONE)) begin
					val_q <= Q_ONE;
				end else begin
					val_q <= alu_res.value[Q_FRAC+AVG_W-1:Q_FRAC];
				end
			end
			S_BAR: begin
				if (alu_res.value[WORD_W-1:Q_FRAC] > (WORD_W - Q_FRAC)'(BAR_MAX)) begin
					barv_q <= BAR_MAX;
				end else begin
					barv_q <= alu_res.value[Q_FRAC+BAR_W-1:Q_FRAC];
				end
			end
			S_RED: begin
				if (!alu_res.borrow) begin
					idx_q <= alu_res.value[IW-1:0];
				end
			end
			S_RD: begin
				// Entries not yet written since reset read as zero.
				val_q <= entry_ok ? ring_rdata : '0;
			end
			S_DONE: begin
				if (load_out) begin
					out_avg_q   <= val_q;
					out_bar_q   <= barv_q;
					out_empty_q <= empty_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == 4'(Q_FRAC - 1)) |=> (state_q == S_MUL1))
		else $error("division did not end after its last quotient bit");

	a_rd_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> (idx_q < IW'(HISTORY_DEPTH)))
		else $error("ring read index not reduced below the depth");

	a_avg_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_avg_q <= Q_ONE))
		else $error("result average above one");

	a_wrap_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wrapped_q |=> wrapped_q)
		else $error("ring wrap flag cleared without reset");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && load_out) |=> (cmd.ready && out_valid_q))
		else $error("finished item not handed to the output register");

endmodule
